>>> rtl/mas_pkg.sv
`default_nettype none

package mas_pkg;

  // default sizes
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  // fixed field widths
  localparam int RES_W     = 43;
  localparam int HELD_W    = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int POW_W     = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATH_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_POWER = 2'd2;

  // math modes
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_AVG  = 2'd1;
  localparam logic [1:0] MODE_DEV  = 2'd2;

  // ten to a small power
  function automatic logic [POW_W-1:0] pow10(input logic [1:0] p);
    logic [POW_W-1:0] v;
    case (p)
      2'd0: v = 10'd1;
      2'd1: v = 10'd10;
      2'd2: v = 10'd100;
      2'd3: v = 10'd1000;
      default: v = 10'd1;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mas_in_if.sv
`default_nettype none

interface mas_in_if #(
  parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

>>> rtl/mas_out_if.sv
`default_nettype none

interface mas_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mas_pkg::RES_W-1:0]  result_value;
  logic        [mas_pkg::HELD_W-1:0] samples_held;

  modport source (output valid, output result_value, output samples_held, input ready);
  modport sink   (input valid, input result_value, input samples_held, output ready);
endinterface

`default_nettype wire

>>> rtl/moving_average_stddev_top.sv
// Moving average / moving standard deviation over a window ring in one memory.
// Pass mode hands the scaled sample straight on; average mode trims the window and divides the sum
// with a bit-serial divider; deviation mode (window longer than one) also walks the window, then uses
// a shift-add multiplier, the bit-serial divider and a bit-serial root.
// One word is in work at a time; a new word is taken while the last result waits.
// Reset (synchronous, rst high) empties the window, clears the sum and loads register defaults.
`default_nettype none

module moving_average_stddev_top #(
  parameter int WINDOW_MAX  = mas_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mas_pkg::CFG_W-1:0]       cfg_data,
  mas_in_if.sink                          in_ch,
  mas_out_if.source                       out_ch
);
  import mas_pkg::*;

  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int XW   = SAMPLE_BITS + POW_W;
  localparam int SW   = XW + CW;
  localparam int PW   = 2 * XW;
  localparam int SQW  = PW + CW;
  localparam int NQW  = 2 * SW;
  localparam int DVW  = NQW + 16;
  localparam int DW   = 2 * CW;
  localparam int RW   = (DVW + 1) / 2;
  localparam int VW   = 2 * RW;
  localparam int CNTW = $clog2(DVW + 1);
  localparam logic [CW:0] WMAX_C = (CW+1)'(WINDOW_MAX);

  typedef enum logic [3:0] {
    S_IDLE, S_TRIM, S_TRIM_RD, S_STORE, S_PREP, S_WALK,
    S_MUL1, S_MUL2, S_DIV, S_SQRT, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [1:0] math_mode;
  logic [8:0] window_len;
  logic [1:0] scale_power;

  // window state
  logic [AW-1:0]        ws;
  logic [CW-1:0]        fc;
  logic signed [SW-1:0] rsum;

  // item context
  logic signed [XW-1:0] x;
  logic [1:0]           mode_q;
  logic [CW-1:0]        len;

  // memory
  logic signed [XW-1:0] mem [WINDOW_MAX];
  logic signed [XW-1:0] rd_data;
  logic                 mem_we;
  logic [AW-1:0]        mem_ra;

  // walk
  logic [AW-1:0] wa;
  logic [CW-1:0] ic;
  logic          v1, v2;
  logic [PW-1:0] sqr;
  logic [SQW-1:0] sq;

  // multiplier
  logic [NQW-1:0] mul_a, acc, q;
  logic [SW-1:0]  mul_b;

  // divider and root
  logic [DVW-1:0]  num;
  logic [DW-1:0]   rem, dvs;
  logic [CNTW-1:0] cnt;
  logic            neg;
  logic [RW+1:0]   rrem;
  logic [RW-1:0]   root;
  logic [VW-1:0]   v;
  logic [RES_W-1:0] res;

  // combinational helpers
  logic signed [XW-1:0] x_mul;
  logic [CW-1:0]        len_eff;
  logic [CW:0]          osum;
  logic [AW-1:0]        oldest;
  logic [SW-1:0]        sabs;
  logic [XW-1:0]        rd_mag;
  logic [PW-1:0]        sq_full;
  logic [DW:0]          rem_sh;
  logic                 div_ge;
  logic [DVW-1:0]       num_next;
  logic [RW+2:0]        r2, rt;
  logic                 sq_ge;
  logic [RW-1:0]        root_next;
  logic                 in_acc;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
    return (a == AW'(WINDOW_MAX - 1)) ? '0 : a + AW'(1);
  endfunction

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  // scaled sample
  assign x_mul = XW'(in_ch.sample_value) * $signed({1'b0, pow10(scale_power)});

  // effective window length
  always_comb begin
    if (window_len == 9'd0) begin
      len_eff = CW'(1);
    end else if (32'(window_len) > WINDOW_MAX) begin
      len_eff = CW'(WINDOW_MAX);
    end else begin
      len_eff = CW'(window_len);
    end
  end

  // oldest slot of the ring
  assign osum   = (CW+1)'(ws) + WMAX_C - (CW+1)'(fc);
  assign oldest = (osum >= WMAX_C) ? AW'(osum - WMAX_C) : AW'(osum);

  assign sabs    = rsum[SW-1] ? SW'(-rsum) : SW'(rsum);

  // square of the stored sample magnitude
  assign rd_mag  = rd_data[XW-1] ? XW'(-rd_data) : XW'(rd_data);
  assign sq_full = PW'(rd_mag) * PW'(rd_mag);

  // restoring divider step
  assign rem_sh   = {rem, num[DVW-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs};
  assign num_next = {num[DVW-2:0], div_ge};

  // root digit step
  assign r2        = {rrem[RW:0], v[VW-1 -: 2]};
  assign rt        = {1'b0, root, 2'b01};
  assign sq_ge     = r2 >= rt;
  assign root_next = {root[RW-2:0], sq_ge};

  // memory ports
  assign mem_we = (state == S_STORE);
  assign mem_ra = (state == S_WALK) ? wa : oldest;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ws] <= x;
    end
    rd_data <= mem[mem_ra];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      math_mode   <= MODE_PASS;
      window_len  <= 9'd1;
      scale_power <= 2'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MATH_MODE) begin
        math_mode <= cfg_data[1:0];
      end
      if (cfg_index == CFG_WINDOW_LEN) begin
        window_len <= cfg_data[8:0];
      end
      if (cfg_index == CFG_SCALE_POWER) begin
        scale_power <= cfg_data[1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ws           <= '0;
      fc           <= '0;
      rsum         <= '0;
      out_ch.valid <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_FIN) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            x      <= x_mul;
            mode_q <= math_mode;
            len    <= len_eff;
            if (math_mode == MODE_AVG || math_mode == MODE_DEV) begin
              state <= S_TRIM;
            end else begin
              res   <= RES_W'(signed'({x_mul, 8'b0}));
              state <= S_FIN;
            end
          end
        end
        // drop oldest samples until there is room
        S_TRIM: begin
          state <= (fc >= len) ? S_TRIM_RD : S_STORE;
        end
        S_TRIM_RD: begin
          rsum  <= rsum - SW'(rd_data);
          fc    <= fc - CW'(1);
          state <= S_TRIM;
        end
        S_STORE: begin
          ws    <= slot_inc(ws);
          fc    <= fc + CW'(1);
          rsum  <= rsum + SW'(x);
          state <= S_PREP;
        end
        S_PREP: begin
          rem <= '0;
          cnt <= '0;
          if (mode_q == MODE_AVG) begin
            num   <= DVW'({sabs, 8'b0});
            dvs   <= DW'(fc);
            neg   <= rsum[SW-1];
            state <= S_DIV;
          end else if (len <= CW'(1)) begin
            res   <= '0;
            state <= S_FIN;
          end else begin
            wa    <= oldest;
            ic    <= '0;
            v1    <= 1'b0;
            v2    <= 1'b0;
            sq    <= '0;
            state <= S_WALK;
          end
        end
        // sum of squares over the window, read then square then add
        S_WALK: begin
          if (ic != fc) begin
            wa <= slot_inc(wa);
            ic <= ic + CW'(1);
            v1 <= 1'b1;
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1;
          if (v1) begin
            sqr <= sq_full;
          end
          if (v2) begin
            sq <= sq + SQW'(sqr);
          end
          if (ic == fc && !v1 && !v2) begin
            mul_a <= NQW'(sq);
            mul_b <= SW'(fc);
            acc   <= '0;
            state <= S_MUL1;
          end
        end
        // n times sum of squares
        S_MUL1: begin
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            q     <= acc;
            mul_a <= NQW'(sabs);
            mul_b <= sabs;
            acc   <= '0;
            state <= S_MUL2;
          end
        end
        // minus sum squared, then scale for the divide
        S_MUL2: begin
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            num   <= {q - acc, 16'b0};
            dvs   <= DW'(fc) * DW'(len - CW'(1));
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= div_ge ? DW'(rem_sh - {1'b0, dvs}) : DW'(rem_sh);
          num <= num_next;
          if (cnt == CNTW'(DVW - 1)) begin
            if (mode_q == MODE_AVG) begin
              res   <= neg ? -RES_W'(num_next) : RES_W'(num_next);
              state <= S_FIN;
            end else begin
              v     <= VW'(num_next);
              rrem  <= '0;
              root  <= '0;
              cnt   <= '0;
              state <= S_SQRT;
            end
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_SQRT: begin
          rrem <= sq_ge ? (RW+2)'(r2 - rt) : (RW+2)'(r2);
          root <= root_next;
          v    <= v << 2;
          cnt  <= cnt + CNTW'(1);
          if (cnt == CNTW'(RW - 1)) begin
            res   <= RES_W'(root_next);
            state <= S_FIN;
          end
        end
        // hand the result to the output register
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid        <= 1'b1;
            out_ch.result_value <= res;
            out_ch.samples_held <= HELD_W'(fc);
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fc) <= WINDOW_MAX)
    else $error("fill count above window size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("sequencer idle after accepting a word");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_ch.valid || out_ch.ready)) |=> out_ch.valid)
    else $error("result not presented after finish");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> ic <= fc)
    else $error("window walk ran past fill count");
`endif

endmodule

`default_nettype wire
